>>> hw/rtl/sha256_pkg.sv
package sha256_pkg;

	typedef logic [31:0] word_t;
	typedef logic [0:7][31:0] hash_t;

	// Control from the byte sequencer to the compression core
	typedef struct packed {
		logic init;   // return hash words to the initial values
		logic push;   // shift one message word into the schedule window
		logic start;  // begin the 64 rounds on the loaded block
	} core_ctl_t;

	localparam int ROUNDS = 64;

	localparam hash_t IV_HASH = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TABLE [0:ROUNDS-1] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

>>> hw/rtl/sha256_round.sv
module sha256_round (
	input  sha256_pkg::hash_t v,
	input  sha256_pkg::word_t k,
	input  sha256_pkg::word_t w,
	output sha256_pkg::hash_t v_next
);
	import sha256_pkg::*;

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	// One compression round on the working variables a..h
	always_comb begin
		ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
		maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t1  = v[7] + big_sig1(v[4]) + ch + k + w;
		t2  = big_sig0(v[0]) + maj;
		v_next[0] = t1 + t2;
		v_next[1] = v[0];
		v_next[2] = v[1];
		v_next[3] = v[2];
		v_next[4] = v[3] + t1;
		v_next[5] = v[4];
		v_next[6] = v[5];
		v_next[7] = v[6];
	end

endmodule

>>> hw/rtl/sha256_core.sv
module sha256_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::core_ctl_t ctl,
	input  sha256_pkg::word_t     push_word,
	output logic                  done,
	output sha256_pkg::hash_t     hash
);
	import sha256_pkg::*;

	word_t       w_q [0:15];
	hash_t       v_q;
	hash_t       h_q;
	hash_t       v_round;
	word_t       w_new;
	word_t       w_in;
	logic [5:0]  rnd_q;
	logic        run_q;
	logic        add_q;

	sha256_round u_round (
		.v      (v_q),
		.k      (K_TABLE[rnd_q]),
		.w      (w_q[0]),
		.v_next (v_round)
	);

	// Message schedule: next word from the 16-word window
	assign w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
	assign w_in  = run_q ? w_new : push_word;

	// Schedule window shifts on each loaded word and each round
	always_ff @(posedge clk) begin
		if (ctl.push || run_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_in;
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= h_q;
		end else if (run_q) begin
			v_q <= v_round;
		end
	end

	// Round sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			add_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			add_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					run_q <= 1'b0;
					add_q <= 1'b1;
				end
			end
		end
	end

	// Hash words: feed-forward add after the last round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= IV_HASH;
		end else if (ctl.init) begin
			h_q <= IV_HASH;
		end else if (add_q) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	assign done = add_q;
	assign hash = h_q;

endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// Takes one message byte per cycle while a block fills; the 64th byte of a
// block stalls input through the 64 rounds of the shared round unit and the
// feed-forward add. End of message: 9 to 72 padding bytes, one per cycle outside
// compressions, one or two compressions, then 8 digest words, one per transfer.
// Asynchronous active-low reset: initial hash values, empty block, zero length.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	import sha256_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_COMP = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t      state_q;
	logic [23:0] acc_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        pad_q;
	logic        sent80_q;
	logic        len_ok_q;
	logic        last_q;
	logic [2:0]  idx_q;

	core_ctl_t   ctl;
	logic        core_done;
	hash_t       hash;

	logic        in_xfer;
	logic        out_xfer;
	logic        push_en;
	logic [7:0]  push_byte;
	logic [7:0]  pad_byte;
	logic        len_zone;
	logic [5:0]  len_amt;
	logic [63:0] len_sh;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign len_zone = (fill_q[5:3] == 3'b111);

	// Padding byte: 0x80, zeros, then the big-endian bit length
	assign len_amt = {3'd7 - fill_q[2:0], 3'b000};
	assign len_sh  = bits_q >> len_amt;
	always_comb begin
		if (!sent80_q) begin
			pad_byte = 8'h80;
		end else if (len_ok_q && len_zone) begin
			pad_byte = len_sh[7:0];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Byte into the block, from the input or the padding
	assign push_en   = (in_xfer && has_byte) || (state_q == ST_PAD);
	assign push_byte = (state_q == ST_PAD) ? pad_byte : data_byte;

	always_comb begin
		ctl.push  = push_en && (fill_q[1:0] == 2'b11);
		ctl.start = push_en && (fill_q == 6'd63);
		ctl.init  = out_xfer && (idx_q == 3'd7);
	end

	sha256_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.push_word ({acc_q, push_byte}),
		.done      (core_done),
		.hash      (hash)
	);

	// Byte packing into words
	always_ff @(posedge clk) begin
		if (push_en) begin
			acc_q <= {acc_q[15:0], push_byte};
		end
	end

	// Sequencer and message bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			pad_q    <= 1'b0;
			sent80_q <= 1'b0;
			len_ok_q <= 1'b0;
			last_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (has_byte) begin
							bits_q <= bits_q + 64'd8;
						end
						if (end_of_message) begin
							pad_q <= 1'b1;
						end
						if (has_byte && fill_q == 6'd63) begin
							state_q <= ST_COMP;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!sent80_q) begin
						sent80_q <= 1'b1;
						if (!len_zone) begin
							len_ok_q <= 1'b1;
						end
					end
					if (fill_q == 6'd63) begin
						if (len_ok_q) begin
							last_q <= 1'b1;
						end else begin
							len_ok_q <= 1'b1;
						end
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (core_done) begin
						if (last_q) begin
							state_q <= ST_OUT;
							idx_q   <= '0;
						end else if (pad_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OUT: begin
					if (out_xfer) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q  <= ST_IDLE;
							bits_q   <= '0;
							pad_q    <= 1'b0;
							sent80_q <= 1'b0;
							len_ok_q <= 1'b0;
							last_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digest output
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = hash[idx_q];
	assign word_index  = idx_q;
	assign digest_last = (idx_q == 3'd7);

endmodule

>>> hw/rtl/sha256_chk.sv
module sha256_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        end_of_message,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        digest_last
);

	// No input transfer while the digest is being sent
	a_busy_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input not stalled during digest output");

	// An end-of-message transfer makes the block busy
	a_end_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && end_of_message) |=> in_stall)
		else $error("block idle right after end of message");

	// Digest words come in order with no gap
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !digest_last) |=>
			(out_valid && word_index == 3'($past(word_index) + 3'd1)))
		else $error("digest word order broken");

	// Nothing follows the last digest word
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && digest_last) |=> !out_valid)
		else $error("output continues after last digest word");

	// Stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(digest_word)))
		else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher sha256_chk u_sha256_chk (.*);
